// File: rtl/gpr_pkg.sv
`timescale 1ns / 1ps

package gpr_pkg;

   localparam int DATA_W      = 16;
   localparam int CFG_DATA_W  = 11;
   localparam int CFG_IDX_W   = 2;
   localparam int LEVEL_W     = 2;
   localparam int POS_W       = 11;   // image_width and image_height never exceed 2047
   localparam int ROW_W       = 10;
   localparam int MAX_ROWS    = 1024;
   localparam int MIN_SIZE    = 4;
   localparam int MAX_COLS_DEF = 1024;
   localparam int STORED_ROWS = 4;
   localparam int LANE_W      = 2;
   localparam int TAPS        = 5;
   localparam int SUM_W       = 25;

   localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CFG_IDX_W-1:0] REG_LEVEL_SHIFT  = 2'd2;

   localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd1024;
   localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 11'd1024;
   localparam logic [LEVEL_W-1:0]    LEVEL_RESET  = 2'd1;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_NONE  = 2'd0;
   localparam kind_type KIND_LEFT  = 2'd1;
   localparam kind_type KIND_RIGHT = 2'd2;
   localparam kind_type KIND_FULL  = 2'd3;

   // index 0 is the newest tap, index 4 the oldest
   typedef logic [TAPS-1:0][DATA_W-1:0] taps_type;

   typedef struct packed {
      kind_type           kind;
      logic [POS_W-1:0]   centre;
   } tap_sel_type;

   // Decide whether the newest position closes a filter window, and where its centre is.
   function automatic tap_sel_type tap_kind(input logic [POS_W-1:0] pos,
                                            input logic [POS_W-1:0] len,
                                            input logic [LEVEL_W-1:0] sh);
      logic [POS_W-1:0] mask;
      logic [POS_W-1:0] outs;
      logic [POS_W-1:0] c;
      tap_sel_type      res;
      mask       = (POS_W'(1) << sh) - POS_W'(1);
      outs       = len >> sh;
      res.kind   = KIND_NONE;
      res.centre = '0;
      c          = pos - POS_W'(2);
      if (pos >= POS_W'(2) && (c & mask) == '0 && (c >> sh) < outs &&
          (c + POS_W'(1)) != (len - POS_W'(1))) begin
         res.kind   = (c == '0) ? KIND_LEFT : KIND_FULL;
         res.centre = c;
      end else begin
         c = pos - POS_W'(1);
         if (pos >= POS_W'(1) && pos == (len - POS_W'(1)) && (c & mask) == '0 &&
             (c >> sh) < outs && c >= POS_W'(2)) begin
            res.kind   = KIND_RIGHT;
            res.centre = c;
         end
      end
      return res;
   endfunction

endpackage

// File: rtl/gpr_tap5.sv
`timescale 1ns / 1ps

// Five-tap 13/64/102/64/13 kernel with edge tap dropping, rounded to nearest.
module gpr_tap5 (
   input  gpr_pkg::kind_type           kind,
   input  gpr_pkg::taps_type           taps,
   output logic [gpr_pkg::DATA_W-1:0]  result
);

   gpr_pkg::taps_type                 u;
   logic [gpr_pkg::SUM_W-1:0]         sum;

   always_comb begin
      case (kind)
         gpr_pkg::KIND_LEFT: begin
            u = {16'd0, 16'd0, taps[2], taps[1], taps[0]};
         end
         gpr_pkg::KIND_RIGHT: begin
            // shift so the newest sample lands on a 64 weight
            u = {taps[3], taps[2], taps[1], taps[0], 16'd0};
         end
         default: begin
            u = taps;
         end
      endcase
   end

   always_comb begin
      sum = gpr_pkg::SUM_W'(u[0]) * 25'd13
          + gpr_pkg::SUM_W'(u[1]) * 25'd64
          + gpr_pkg::SUM_W'(u[2]) * 25'd102
          + gpr_pkg::SUM_W'(u[3]) * 25'd64
          + gpr_pkg::SUM_W'(u[4]) * 25'd13
          + 25'd128;
   end

   assign result = sum[8 +: gpr_pkg::DATA_W];

endmodule

// File: rtl/gaussian_pyramid_reduce.sv
`timescale 1ns / 1ps

// Gaussian pyramid reduce: one luminance frame (unsigned 8.8) in raster order on the
// req_ channel, the frame reduced by 2^level_shift per axis (level 0 acts as 1) on the
// rsp_ channel, also in raster order, with rsp_frame_done on the last reduced pixel.
// The csr_ port sets image_width, image_height and level_shift; write it only while the
// block is idle. Any register write restarts the frame at column 0, row 0.
// Throughput: one sample per clock. A sample that completes a reduced pixel shows up on
// rsp_valid when its result reaches the output register. The path is accept (line store read),
// horizontal pass, vertical pass, output register; horizontal results are written back
// to a 4-row line store organized as one word of four row lanes per reduced column, so
// the vertical pass needs a single read.
// When the receiver stalls, the output register holds its transaction. Samples that
// complete no reduced pixel keep flowing; req_ready drops once a completed pixel waits in
// the vertical pass and the horizontal pass is occupied.
// Synchronous reset clears the pipeline, counters, sample history and the registers to
// 1024 x 1024 at level one. The line store is not cleared; a normal frame fills each row
// before reading it.
module gaussian_pyramid_reduce #(
   parameter int MAX_COLS = gpr_pkg::MAX_COLS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [gpr_pkg::DATA_W-1:0]          req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [gpr_pkg::DATA_W-1:0]          rsp_reduced_sample,
   output logic                                rsp_frame_done,
   input  logic                                csr_write,
   input  logic [gpr_pkg::CFG_IDX_W-1:0]       csr_index,
   input  logic [gpr_pkg::CFG_DATA_W-1:0]      csr_wdata
);

   localparam int ROW_SLOTS = MAX_COLS / 2;
   localparam int ADDR_W    = $clog2(ROW_SLOTS);
   localparam int COL_W     = $clog2(MAX_COLS);
   localparam int POS_W     = gpr_pkg::POS_W;
   localparam int DATA_W    = gpr_pkg::DATA_W;
   localparam int LANES     = gpr_pkg::STORED_ROWS;
   localparam int LANE_W    = gpr_pkg::LANE_W;
   localparam logic [POS_W-1:0] W_MAX =
      POS_W'((MAX_COLS < (1 << POS_W)) ? MAX_COLS : ((1 << POS_W) - 1));
   localparam logic [POS_W-1:0] H_MAX    = POS_W'(gpr_pkg::MAX_ROWS);
   localparam logic [POS_W-1:0] SIZE_MIN = POS_W'(gpr_pkg::MIN_SIZE);

   // configuration
   logic [gpr_pkg::CFG_DATA_W-1:0] width_ff;
   logic [gpr_pkg::CFG_DATA_W-1:0] height_ff;
   logic [gpr_pkg::LEVEL_W-1:0]    level_ff;
   logic                           cfg_hit;

   logic [POS_W-1:0]               w_eff;
   logic [POS_W-1:0]               h_eff;
   logic [gpr_pkg::LEVEL_W-1:0]    sh;

   // position and sample history
   logic [COL_W-1:0]               col_ff, col_in;
   logic [gpr_pkg::ROW_W-1:0]      row_ff, row_in;
   logic [LANES-1:0][DATA_W-1:0]   recent_ff;

   // accept side
   logic                           accept;
   logic [POS_W-1:0]               x_pos;
   logic [POS_W-1:0]               y_pos;
   gpr_pkg::tap_sel_type           hsel;
   gpr_pkg::tap_sel_type           vsel;
   logic [ADDR_W-1:0]              rd_addr;
   logic                           done_flag;

   // line store
   logic [LANES-1:0][DATA_W-1:0]   mem [ROW_SLOTS];
   logic [LANES-1:0][DATA_W-1:0]   mem_rd_ff;

   // horizontal pass
   logic                           b_valid_ff, b_valid_in;
   gpr_pkg::taps_type              b_taps_ff;
   gpr_pkg::kind_type              b_hkind_ff;
   gpr_pkg::kind_type              b_vkind_ff;
   logic [LANE_W-1:0]              b_lane_ff;
   logic [LANES-1:0]               b_vmask_ff;
   logic [ADDR_W-1:0]              b_addr_ff;
   logic                           b_done_ff;
   logic                           b_move;
   logic [DATA_W-1:0]              hval;
   gpr_pkg::taps_type              vtaps;

   // vertical pass
   logic                           c_valid_ff, c_valid_in;
   gpr_pkg::taps_type              c_taps_ff;
   gpr_pkg::kind_type              c_vkind_ff;
   logic                           c_hwrite_ff;
   logic [LANE_W-1:0]              c_lane_ff;
   logic [ADDR_W-1:0]              c_addr_ff;
   logic                           c_done_ff;
   logic                           c_produce;
   logic                           c_move;
   logic                           c_free;
   logic [DATA_W-1:0]              rval;

   // output register
   logic                           o_valid_ff, o_valid_in;
   logic [DATA_W-1:0]              o_data_ff;
   logic                           o_done_ff;
   logic                           o_free;

   // ---------------- configuration ----------------
   assign cfg_hit = csr_write && (csr_index == gpr_pkg::REG_IMAGE_WIDTH ||
                                  csr_index == gpr_pkg::REG_IMAGE_HEIGHT ||
                                  csr_index == gpr_pkg::REG_LEVEL_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= gpr_pkg::WIDTH_RESET;
         height_ff <= gpr_pkg::HEIGHT_RESET;
         level_ff  <= gpr_pkg::LEVEL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            gpr_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            gpr_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
            gpr_pkg::REG_LEVEL_SHIFT:  level_ff  <= csr_wdata[gpr_pkg::LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff < SIZE_MIN) begin
         w_eff = SIZE_MIN;
      end else if (width_ff > W_MAX) begin
         w_eff = W_MAX;
      end else begin
         w_eff = width_ff;
      end
      if (height_ff < SIZE_MIN) begin
         h_eff = SIZE_MIN;
      end else if (height_ff > H_MAX) begin
         h_eff = H_MAX;
      end else begin
         h_eff = height_ff;
      end
      sh = (level_ff == '0) ? gpr_pkg::LEVEL_W'(1) : level_ff;
   end

   // ---------------- accept side ----------------
   assign req_ready = !b_valid_ff || b_move;
   assign accept    = req_valid && req_ready;

   assign x_pos = POS_W'(col_ff);
   assign y_pos = POS_W'(row_ff);

   always_comb begin
      hsel      = gpr_pkg::tap_kind(x_pos, w_eff, sh);
      vsel      = gpr_pkg::tap_kind(y_pos, h_eff, sh);
      rd_addr   = ADDR_W'(hsel.centre >> sh);
      done_flag = ((vsel.centre >> sh) == ((h_eff >> sh) - POS_W'(1))) &&
                  ((hsel.centre >> sh) == ((w_eff >> sh) - POS_W'(1)));
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if ((x_pos + POS_W'(1)) >= w_eff) begin
            col_in = '0;
            row_in = ((y_pos + POS_W'(1)) >= h_eff) ? '0 : row_ff + gpr_pkg::ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         recent_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (accept) begin
            recent_ff <= {recent_ff[LANES-2:0], req_sample};
         end
      end
   end

   // ---------------- line store ----------------
   // A read of an entry always comes a full image row after the write it needs, so no forwarding.
   always_ff @(posedge clock) begin
      if (c_move && c_hwrite_ff) begin
         mem[c_addr_ff][c_lane_ff] <= c_taps_ff[0];
      end
      if (accept) begin
         mem_rd_ff <= mem[rd_addr];
      end
   end

   // ---------------- horizontal pass ----------------
   always_comb begin
      b_valid_in = b_valid_ff;
      if (accept) begin
         b_valid_in = 1'b1;
      end else if (b_move) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_taps_ff  <= {recent_ff[3], recent_ff[2], recent_ff[1], recent_ff[0], req_sample};
         b_hkind_ff <= hsel.kind;
         b_vkind_ff <= (hsel.kind == gpr_pkg::KIND_NONE) ? gpr_pkg::KIND_NONE : vsel.kind;
         b_lane_ff  <= row_ff[LANE_W-1:0];
         b_vmask_ff <= {row_ff >= gpr_pkg::ROW_W'(4), row_ff >= gpr_pkg::ROW_W'(3),
                        row_ff >= gpr_pkg::ROW_W'(2), row_ff >= gpr_pkg::ROW_W'(1)};
         b_addr_ff  <= rd_addr;
         b_done_ff  <= done_flag;
      end
   end

   gpr_tap5 u_hpass (
      .kind   (b_hkind_ff),
      .taps   (b_taps_ff),
      .result (hval)
   );

   // Row y-k sits in lane (y-k) mod 4; rows above the image read as zero.
   always_comb begin
      vtaps[0] = hval;
      for (int k = 1; k < gpr_pkg::TAPS; k++) begin
         vtaps[k] = b_vmask_ff[k-1] ? mem_rd_ff[b_lane_ff - LANE_W'(k)] : '0;
      end
   end

   assign b_move = b_valid_ff && c_free;

   // ---------------- vertical pass ----------------
   assign o_free    = !o_valid_ff || rsp_ready;
   assign c_produce = (c_vkind_ff != gpr_pkg::KIND_NONE);
   assign c_move    = c_valid_ff && (!c_produce || o_free);
   assign c_free    = !c_valid_ff || c_move;

   always_comb begin
      c_valid_in = c_valid_ff;
      if (b_move) begin
         c_valid_in = 1'b1;
      end else if (c_move) begin
         c_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_move) begin
         c_taps_ff   <= vtaps;
         c_vkind_ff  <= b_vkind_ff;
         c_hwrite_ff <= (b_hkind_ff != gpr_pkg::KIND_NONE);
         c_lane_ff   <= b_lane_ff;
         c_addr_ff   <= b_addr_ff;
         c_done_ff   <= b_done_ff;
      end
   end

   gpr_tap5 u_vpass (
      .kind   (c_vkind_ff),
      .taps   (c_taps_ff),
      .result (rval)
   );

   // ---------------- output register ----------------
   always_comb begin
      o_valid_in = o_valid_ff;
      if (c_move && c_produce) begin
         o_valid_in = 1'b1;
      end else if (rsp_ready) begin
         o_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else begin
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (c_move && c_produce) begin
         o_data_ff <= rval;
         o_done_ff <= c_done_ff;
      end
   end

   assign rsp_valid          = o_valid_ff;
   assign rsp_reduced_sample = o_data_ff;
   assign rsp_frame_done     = o_done_ff;

endmodule

// File: rtl/gpr_checker.sv
`timescale 1ns / 1ps

module gpr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [gpr_pkg::DATA_W-1:0]          req_sample,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [gpr_pkg::DATA_W-1:0]          rsp_reduced_sample,
   input logic                                rsp_frame_done,
   input logic                                csr_write,
   input logic [gpr_pkg::CFG_IDX_W-1:0]       csr_index,
   input logic [gpr_pkg::CFG_DATA_W-1:0]      csr_wdata
);

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reduced_sample) &&
                                  $stable(rsp_frame_done))
      else $error("rsp transaction changed while stalled");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // input backpressure only comes from a stalled output with the pipeline full
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req_ready low without an output stall");

   // ready is high once the output register has stayed empty
   a_ready_back: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid ##1 !rsp_valid |-> req_ready)
      else $error("req_ready low while output idle");

endmodule

bind gaussian_pyramid_reduce gpr_checker u_gpr_checker (.*);

// File: tb/gaussian_pyramid_reduce_test.sv
`timescale 1ns / 1ps

module gaussian_pyramid_reduce_test;
   import gpr_pkg::*;

   typedef enum {FILL_ZERO, FILL_FULL, FILL_CHECKER, FILL_RANDOM} fill_kind;

   // Tracks the block's configuration, sample history and line store, and queues
   // the reduced pixels each accepted sample should produce.
   class pyramid_tracker;
      typedef struct packed {
         logic [DATA_W-1:0] pix;
         logic              last;
      } reduced_px;

      logic [CFG_DATA_W-1:0] cfg_w, cfg_h;
      logic [LEVEL_W-1:0]    cfg_level;
      logic [DATA_W-1:0]     line_rows [STORED_ROWS][512];
      logic [DATA_W-1:0]     history [4];
      int unsigned           col, row;
      reduced_px             due_pixels [$];
      int                    faults, matched;

      function new();
         cfg_w = WIDTH_RESET;
         cfg_h = HEIGHT_RESET;
         cfg_level = LEVEL_RESET;
         foreach (line_rows[i, j]) line_rows[i][j] = '0;
         foreach (history[i]) history[i] = '0;
         col = 0;
         row = 0;
         faults = 0;
         matched = 0;
      endfunction

      function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
         case (idx)
            REG_IMAGE_WIDTH: cfg_w = val;
            REG_IMAGE_HEIGHT: cfg_h = val;
            REG_LEVEL_SHIFT: cfg_level = val[LEVEL_W-1:0];
            default: return;
         endcase
         // any write restarts the frame
         col = 0;
         row = 0;
      endfunction

      function int unsigned bound(int unsigned v, int unsigned lo, int unsigned hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      // Does the newest position close a 5-tap window, and where is its centre
      function kind_type window(int unsigned pos, int unsigned len, int unsigned sh,
                                output int unsigned centre);
         int unsigned mask, outs, c;
         mask = (1 << sh) - 1;
         outs = len >> sh;
         centre = 0;
         if (pos >= 2) begin
            c = pos - 2;
            if ((c & mask) == 0 && (c >> sh) < outs && c + 1 != len - 1) begin
               centre = c;
               return (c == 0) ? KIND_LEFT : KIND_FULL;
            end
         end
         if (pos >= 1 && pos == len - 1) begin
            c = pos - 1;
            if ((c & mask) == 0 && (c >> sh) < outs && c >= 2) begin
               centre = c;
               return KIND_RIGHT;
            end
         end
         return KIND_NONE;
      endfunction

      // t[0] is the newest tap, t[4] the oldest; edge taps are dropped, not renormalized
      function logic [DATA_W-1:0] blur(kind_type k, int unsigned t[5]);
         int unsigned sum;
         case (k)
            KIND_LEFT: sum = 102 * t[2] + 64 * t[1] + 13 * t[0];
            KIND_RIGHT: sum = 13 * t[3] + 64 * t[2] + 102 * t[1] + 64 * t[0];
            default: sum = 13 * t[4] + 64 * t[3] + 102 * t[2] + 64 * t[1] + 13 * t[0];
         endcase
         return DATA_W'((sum + 128) >> 8);
      endfunction

      function void take_sample(logic [DATA_W-1:0] s);
         int unsigned w, h, sh, x, y, cx, cy, j;
         int unsigned t[5], v[5];
         kind_type hk, vk;
         logic [DATA_W-1:0] hval;
         reduced_px px;
         w = bound(cfg_w, MIN_SIZE, MAX_COLS_DEF);
         h = bound(cfg_h, MIN_SIZE, MAX_ROWS);
         sh = (cfg_level == 0) ? 1 : cfg_level;
         x = (col >= w) ? w - 1 : col;
         y = (row >= h) ? h - 1 : row;
         t[0] = s;
         for (int k = 1; k < 5; k++) t[k] = history[k-1];
         hk = window(x, w, sh, cx);
         if (hk != KIND_NONE) begin
            hval = blur(hk, t);
            j = (cx >> sh) & 511;
            vk = window(y, h, sh, cy);
            if (vk != KIND_NONE) begin
               v[0] = hval;
               for (int k = 1; k < 5; k++) v[k] = (y >= k) ? line_rows[(y - k) & 3][j] : 0;
               px.pix = blur(vk, v);
               px.last = ((cy >> sh) == (h >> sh) - 1) && ((cx >> sh) == (w >> sh) - 1);
               due_pixels.push_back(px);
            end
            line_rows[y & 3][j] = hval;
         end
         history[3] = history[2];
         history[2] = history[1];
         history[1] = history[0];
         history[0] = s;
         if (x + 1 >= w) begin
            col = 0;
            row = (y + 1 >= h) ? 0 : y + 1;
         end else begin
            col = x + 1;
            row = y;
         end
      endfunction

      function void match_pixel(logic [DATA_W-1:0] pix, logic last);
         reduced_px want;
         if (due_pixels.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("unexpected reduced pixel %h frame_done %b at %0t", pix, last, $realtime);
            return;
         end
         want = due_pixels.pop_front();
         matched++;
         if (pix !== want.pix || last !== want.last) begin
            faults++;
            if (faults <= 10)
               $display("pixel %0d: expected %h frame_done %b, got %h frame_done %b",
                        matched, want.pix, want.last, pix, last);
         end
      endfunction

      function int waiting();
         return due_pixels.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [DATA_W-1:0]     req_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [DATA_W-1:0]     rsp_reduced_sample;
   logic                  rsp_frame_done;
   logic                  csr_write = 1'b0;
   logic [CFG_IDX_W-1:0]  csr_index = '0;
   logic [CFG_DATA_W-1:0] csr_wdata = '0;

   int unsigned    tx_idle_pct = 10;
   int unsigned    rx_idle_pct = 86;
   int unsigned    random_items = 0;
   pyramid_tracker book = new();

   gaussian_pyramid_reduce uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_reduced_sample(rsp_reduced_sample),
      .rsp_frame_done(rsp_frame_done),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      if (!reset && rsp_valid && rsp_ready)
         book.match_pixel(rsp_reduced_sample, rsp_frame_done);
   end

   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [DATA_W-1:0] pick_sample(fill_kind f, int unsigned n);
      case (f)
         FILL_ZERO: return '0;
         FILL_FULL: return '1;
         FILL_CHECKER: return n[0] ? '1 : '0;
         default: begin
            case ($urandom_range(0, 9))
               0: return '0;
               1: return '1;
               default: return DATA_W'($urandom);
            endcase
         end
      endcase
   endfunction

   task automatic push_sample(input logic [DATA_W-1:0] s);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      book.take_sample(s);
   endtask

   task automatic feed(input int unsigned count, input fill_kind f);
      for (int unsigned i = 0; i < count; i++) push_sample(pick_sample(f, i));
   endtask

   // Hold the sender until every reduced pixel is out, then let the pipeline empty
   task automatic drain();
      req_valid <= 1'b0;
      while (book.waiting() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                            input logic [LEVEL_W-1:0] lvl);
      logic [CFG_DATA_W-1:0] vals [3];
      logic [CFG_IDX_W-1:0]  regs [3];
      vals = '{w, h, CFG_DATA_W'(lvl)};
      regs = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_LEVEL_SHIFT};
      for (int i = 0; i < 3; i++) begin
         csr_write <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         book.write_reg(regs[i], vals[i]);
      end
      csr_write <= 1'b0;
   endtask

   initial begin
      int unsigned w, h, lvl, ew, eh, n, pause_at, frames;
      bit          cut;
      fill_kind    f;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset size 1024 x 1024 at level one: a partial first row produces nothing
      feed(40, FILL_RANDOM);
      drain();
      // smallest frame, back to back across the frame wrap
      configure(4, 4, 1);
      feed(16, FILL_FULL);
      feed(16, FILL_ZERO);
      feed(16, FILL_CHECKER);
      drain();
      // undersized width and height, level zero
      configure(0, 3, 0);
      feed(32, FILL_RANDOM);
      drain();
      // right and bottom edge windows
      configure(10, 10, 1);
      feed(100, FILL_CHECKER);
      drain();
      configure(8, 8, 3);
      feed(64, FILL_FULL);
      drain();
      // too narrow for any output at level three
      configure(4, 4, 3);
      feed(16, FILL_RANDOM);
      drain();

      while (random_items < 400) begin
         if (random_items >= 200) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end else begin
            tx_idle_pct = 86;
            rx_idle_pct = 10;
         end
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 20);
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 12);
         lvl = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
         configure(CFG_DATA_W'(w), CFG_DATA_W'(h), LEVEL_W'(lvl));
         ew = (w < 4) ? 4 : w;
         eh = (h < 4) ? 4 : h;
         frames = $urandom_range(1, 3);
         for (int fr = 0; fr < frames; fr++) begin
            f = ($urandom_range(0, 5) == 0) ? fill_kind'($urandom_range(0, 2)) : FILL_RANDOM;
            n = ew * eh;
            // abandon some frames part way; the next register write restarts
            cut = ($urandom_range(0, 7) == 0);
            if (cut) n = $urandom_range(1, n - 1);
            pause_at = (n > 1 && $urandom_range(0, 5) == 0) ? $urandom_range(1, n - 1) : n;
            for (int unsigned i = 0; i < n && random_items < 400; i++) begin
               if (i == pause_at) drain();
               push_sample(pick_sample(f, i));
               random_items++;
            end
            if (cut || random_items >= 400) break;
         end
         drain();
      end

      repeat (12) @(posedge clock);
      if (book.faults == 0 && book.waiting() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
